// File: hw/rtl/assert_macros.svh
// assertion macros shared by the activation unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is low
`define AFB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("activation unit check failed");
// clocked check that also holds through reset
`define AFB_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("activation unit check failed");
`else
`define AFB_ASSERT(lbl, clk, rst_n, prop)
`define AFB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/afb_pkg.sv
// shared constants and types of the activation forward/backward unit
`default_nettype none
package afb_pkg;
	localparam int VW        = 16;
	localparam int FB        = 11;
	localparam int QSH       = 32 - FB;
	localparam int TW        = VW + QSH + 1;
	localparam int KBITS     = 6;
	localparam int EXP_TERMS = 13;
	localparam int LOG_TERMS = 11;
	localparam int QBITS     = 31;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	// function codes
	localparam logic [2:0] FN_IDENT = 3'd0;
	localparam logic [2:0] FN_SIGM  = 3'd1;
	localparam logic [2:0] FN_TANH  = 3'd2;
	localparam logic [2:0] FN_RELU  = 3'd3;
	localparam logic [2:0] FN_LOGM  = 3'd4;

	// action codes
	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_BWD = 1'b1;

	typedef logic signed [VW-1:0] val_t;

	// everything an element carries down the pipeline
	typedef struct packed {
		logic             act;
		logic [2:0]       fn;
		logic             bad;
		val_t             x;
		val_t             y;
		val_t             g;
		val_t             acc;
		logic [2:0]       lk;
		logic [32:0]      lm;
		logic [32:0]      e;
		logic [QBITS-1:0] q;
		logic [32:0]      lsum;
	} carry_t;
endpackage
`default_nettype wire

// File: hw/rtl/activation_forward_backward_unit.sv
// Elementwise activation unit, forward f(x) and backward derivative-accumulate.
//
// Slave stream carries one element per transaction: tuser selects action and
// function, tdata holds x, y, upstream gradient and accumulator (Q4.11).
// Master stream returns one transaction per element: the Q4.11 result in tdata,
// the saturation and bad-function flags in tuser. Results leave in order.
// From acceptance to m_tvalid an element passes one input register, 33
// stages of exp(-t) (six range-reduction steps, 13 series terms of two stages
// each, one scaling stage), 32 stages of the shared restoring divider, 12 stages
// of the log series and 3 result stages. One element is accepted every cycle
// while the output is not stalled; the divider and series stages are fully pipelined.
// The pipeline advances as one: when m_tvalid is high and m_tready low every
// stage holds and s_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset. The block has no
// state between elements. Function codes 5 to 7 return zero with bad_function.
`default_nettype none
module activation_forward_backward_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // pre_activation, activated_value, upstream_gradient, gradient_accumulator
	input  wire logic [3:0]  s_tuser,  // action, function_select
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // result_value
	output logic [1:0]       m_tuser   // saturated, bad_function
);
	import afb_pkg::*;

	`include "assert_macros.svh"

	logic            adv;
	logic [VW-1:0]   xmag;
	logic [VW-1:0]   ymag;
	logic [TW-2:0]   aq;
	logic [TW-1:0]   tval;
	logic [TW-1:0]   vlog;
	logic [2:0]      lk;
	carry_t          cnew;

	logic [TW-1:0]   t_s1;
	carry_t          c_s1;
	logic            v_s1;

	carry_t          ce;
	logic            ve;
	carry_t          cd;
	logic            vd;
	carry_t          cl;
	logic            vl;
	val_t            result;
	logic            sat;
	logic            bad;

	// whole pipeline moves when the output register is free
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input decode: exp argument and log normalisation
	always_comb begin
		cnew.act  = s_tuser[0];
		cnew.fn   = s_tuser[3:1];
		cnew.bad  = s_tuser[3:1] > FN_LOGM;
		cnew.x    = val_t'(s_tdata[15:0]);
		cnew.y    = val_t'(s_tdata[31:16]);
		cnew.g    = val_t'(s_tdata[47:32]);
		cnew.acc  = val_t'(s_tdata[63:48]);
		cnew.e    = '0;
		cnew.q    = '0;
		cnew.lsum = '0;
		xmag = s_tdata[15] ? (~s_tdata[15:0] + 1'b1) : s_tdata[15:0];
		ymag = s_tdata[31] ? (~s_tdata[31:16] + 1'b1) : s_tdata[31:16];
		aq   = {xmag, {QSH{1'b0}}};
		if (cnew.act == ACT_BWD) tval = TW'({ymag, {QSH{1'b0}}});
		else if (cnew.fn == FN_TANH) tval = {xmag, {(QSH + 1){1'b0}}};
		else tval = TW'(aq);
		vlog = TW'(aq) + TW'(ONE_Q32);
		if (vlog[37]) lk = 3'd5;
		else if (vlog[36]) lk = 3'd4;
		else if (vlog[35]) lk = 3'd3;
		else if (vlog[34]) lk = 3'd2;
		else if (vlog[33]) lk = 3'd1;
		else lk = 3'd0;
		cnew.lk = lk;
		cnew.lm = 33'(vlog >> lk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= tval;
			c_s1 <= cnew;
		end
	end

	afb_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (v_s1),
		.tin    (t_s1),
		.cin    (c_s1),
		.vout   (ve),
		.cout   (ce)
	);

	afb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (ve),
		.cin    (ce),
		.vout   (vd),
		.cout   (cd)
	);

	afb_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (vd),
		.cin    (cd),
		.vout   (vl),
		.cout   (cl)
	);

	afb_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (vl),
		.cin    (cl),
		.vout   (m_tvalid),
		.result (result),
		.sat    (sat),
		.bad    (bad)
	);

	assign m_tdata = result;
	assign m_tuser = {bad, sat};

	// a held result blocks new transactions
	`AFB_ASSERT(a_stall_blocks_input, clk, arst_n, (m_tvalid && !m_tready) |-> !s_tready)
	// an unknown function gives a clean zero
	`AFB_ASSERT_ALWAYS(a_bad_is_zero, clk, (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'h0000 && !m_tuser[0]))
	// clipping only ever lands on a range limit
	`AFB_ASSERT(a_sat_at_limit, clk, arst_n, (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
endmodule
`default_nettype wire

// File: hw/rtl/afb_exp.sv
// exp(-t) pipeline: ln2 range reduction then a 13 term series, one step per stage
`default_nettype none
module afb_exp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     vin,
	input  wire logic [afb_pkg::TW-1:0]   tin,
	input  afb_pkg::carry_t               cin,
	output logic                          vout,
	output afb_pkg::carry_t               cout
);
	import afb_pkg::*;

	localparam int NS = 2 * EXP_TERMS;

	logic [TW-1:0]    rem_s [KBITS+1];
	logic [KBITS-1:0] k_s   [KBITS+1];
	carry_t           rc_s  [KBITS+1];
	logic             rv_s  [KBITS+1];

	logic [32:0]        term_s [NS+1];
	logic [31:0]        prod_s [NS+1];
	logic signed [35:0] sum_s  [NS+1];
	logic [31:0]        r_s    [NS+1];
	logic [KBITS-1:0]   ek_s   [NS+1];
	carry_t             ec_s   [NS+1];
	logic               ev_s   [NS+1];

	carry_t      cf_s;
	logic        vf_s;
	logic [34:0] spos;
	carry_t      cfin;

	assign rem_s[0] = tin;
	assign k_s[0]   = '0;
	assign rc_s[0]  = cin;
	assign rv_s[0]  = vin;

	// range reduction, one quotient bit of t / ln2 per stage
	for (genvar i = 0; i < KBITS; i++) begin : g_red
		localparam int B = KBITS - 1 - i;
		localparam logic [TW-1:0] SUB = TW'(LN2_Q32) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[i+1] <= 1'b0;
			else if (adv) rv_s[i+1] <= rv_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rc_s[i+1] <= rc_s[i];
				if (rem_s[i] >= SUB) begin
					rem_s[i+1] <= rem_s[i] - SUB;
					k_s[i+1]   <= k_s[i] | (KBITS'(1) << B);
				end else begin
					rem_s[i+1] <= rem_s[i];
					k_s[i+1]   <= k_s[i];
				end
			end
		end
	end

	assign term_s[0] = ONE_Q32;
	assign prod_s[0] = '0;
	assign sum_s[0]  = 36'sh1_0000_0000;
	assign r_s[0]    = rem_s[KBITS][31:0];
	assign ek_s[0]   = k_s[KBITS];
	assign ec_s[0]   = rc_s[KBITS];
	assign ev_s[0]   = rv_s[KBITS];

	// series: product stage then exact constant-divide stage per term
	for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_ser
		localparam int A = 2 * n - 1;
		localparam int B = 2 * n;
		localparam int L = $clog2(n);
		localparam logic [63:0] MUL = ((64'd1 << (32 + L)) + 64'(n) - 64'd1) / 64'(n);
		localparam bit ODD = (n % 2) == 1;
		logic [64:0]        pr;
		logic [65:0]        qp;
		logic [31:0]        quo;
		logic signed [35:0] qs;
		assign pr  = term_s[A-1] * r_s[A-1];
		assign qp  = prod_s[A] * MUL[33:0];
		assign quo = 32'(qp >> (32 + L));
		assign qs  = $signed({4'b0, quo});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ev_s[A] <= 1'b0;
				ev_s[B] <= 1'b0;
			end else if (adv) begin
				ev_s[A] <= ev_s[A-1];
				ev_s[B] <= ev_s[A];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s[A] <= pr[63:32];
				term_s[A] <= term_s[A-1];
				sum_s[A]  <= sum_s[A-1];
				r_s[A]    <= r_s[A-1];
				ek_s[A]   <= ek_s[A-1];
				ec_s[A]   <= ec_s[A-1];
				prod_s[B] <= prod_s[A];
				term_s[B] <= {1'b0, quo};
				sum_s[B]  <= ODD ? (sum_s[A] - qs) : (sum_s[A] + qs);
				r_s[B]    <= r_s[A];
				ek_s[B]   <= ek_s[A];
				ec_s[B]   <= ec_s[A];
			end
		end
	end

	// scale by 2^-k, clamp negative sums
	assign spos = sum_s[NS][35] ? '0 : sum_s[NS][34:0];

	always_comb begin
		cfin   = ec_s[NS];
		cfin.e = 33'(spos >> ek_s[NS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vf_s <= 1'b0;
		else if (adv) vf_s <= ev_s[NS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cf_s <= cfin;
		end
	end

	assign vout = vf_s;
	assign cout = cf_s;
endmodule
`default_nettype wire

// File: hw/rtl/afb_div.sv
// restoring divider pipeline, one quotient bit per stage, shared by sigmoid, tanh and log
`default_nettype none
module afb_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vin,
	input  afb_pkg::carry_t   cin,
	output logic              vout,
	output afb_pkg::carry_t   cout
);
	import afb_pkg::*;

	logic [63:0] nn_s [QBITS+1];
	logic [33:0] dd_s [QBITS+1];
	carry_t      dc_s [QBITS+1];
	logic        dv_s [QBITS+1];

	logic [63:0] num;
	logic [33:0] den;
	carry_t      cset;

	// operand set-up per function
	always_comb begin
		case (cin.fn)
			FN_TANH: begin
				num = 64'(ONE_Q32 - cin.e) << 31;
				den = 34'(cin.e) + 34'(ONE_Q32);
			end
			FN_LOGM: begin
				num = {cin.lm[31:0], 32'b0};
				den = 34'(cin.lm) + 34'(ONE_Q32);
			end
			default: begin
				num = 64'(cin.e) << 31;
				den = 34'(cin.e) + 34'(ONE_Q32);
			end
		endcase
	end

	// quotient starts cleared
	always_comb begin
		cset   = cin;
		cset.q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (adv) dv_s[0] <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nn_s[0] <= num;
			dd_s[0] <= den;
			dc_s[0] <= cset;
		end
	end

	// quotient bits, most significant first
	for (genvar i = 0; i < QBITS; i++) begin : g_bit
		localparam int B = QBITS - 1 - i;
		logic [64:0] sub;
		logic        fit;
		carry_t      cnext;
		assign sub = 65'(dd_s[i]) << B;
		assign fit = {1'b0, nn_s[i]} >= sub;
		always_comb begin
			cnext      = dc_s[i];
			cnext.q[B] = fit;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[i+1] <= 1'b0;
			else if (adv) dv_s[i+1] <= dv_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dd_s[i+1] <= dd_s[i];
				dc_s[i+1] <= cnext;
				if (fit) begin
					nn_s[i+1] <= nn_s[i] - sub[63:0];
				end else begin
					nn_s[i+1] <= nn_s[i];
				end
			end
		end
	end

	assign vout = dv_s[QBITS];
	assign cout = dc_s[QBITS];
endmodule
`default_nettype wire

// File: hw/rtl/afb_log.sv
// atanh series for ln(1+a): squares the divider quotient, then one term per stage
`default_nettype none
module afb_log (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vin,
	input  afb_pkg::carry_t   cin,
	output logic              vout,
	output afb_pkg::carry_t   cout
);
	import afb_pkg::*;

	logic [QBITS-1:0] p_s   [LOG_TERMS+1];
	logic [29:0]      s2_s  [LOG_TERMS+1];
	logic [32:0]      ls_s  [LOG_TERMS+1];
	carry_t           lc_s  [LOG_TERMS+1];
	logic             lv_s  [LOG_TERMS+1];

	logic [61:0] sq;

	assign sq = cin.q * cin.q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lv_s[0] <= 1'b0;
		else if (adv) lv_s[0] <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s[0]  <= cin.q;
			s2_s[0] <= sq[61:32];
			ls_s[0] <= '0;
			lc_s[0] <= cin;
		end
	end

	// odd-power terms divided by odd constants
	for (genvar n = 0; n < LOG_TERMS; n++) begin : g_term
		localparam int DV = 2 * n + 1;
		localparam int L = $clog2(DV);
		localparam logic [63:0] MUL = ((64'd1 << (32 + L)) + 64'(DV) - 64'd1) / 64'(DV);
		logic [64:0] qp;
		logic [60:0] pp;
		assign qp = p_s[n] * MUL[33:0];
		assign pp = p_s[n] * s2_s[n];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lv_s[n+1] <= 1'b0;
			else if (adv) lv_s[n+1] <= lv_s[n];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ls_s[n+1] <= ls_s[n] + 33'(qp >> (32 + L));
				p_s[n+1]  <= QBITS'(pp >> 32);
				s2_s[n+1] <= s2_s[n];
				lc_s[n+1] <= lc_s[n];
			end
		end
	end

	always_comb begin
		cout      = lc_s[LOG_TERMS];
		cout.lsum = ls_s[LOG_TERMS];
	end

	assign vout = lv_s[LOG_TERMS];
endmodule
`default_nettype wire

// File: hw/rtl/afb_post.sv
// result stages: forward rounding, backward derivative products, accumulate and clip
`default_nettype none
module afb_post (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         vin,
	input  afb_pkg::carry_t   cin,
	output logic              vout,
	output afb_pkg::val_t     result,
	output logic              sat,
	output logic              bad
);
	import afb_pkg::*;

	function automatic logic [VW-1:0] rnd(input logic [35:0] v);
		rnd = VW'((v + (36'd1 << (QSH - 1))) >> QSH);
	endfunction

	// stage 1 signals
	logic [31:0]        q2;
	logic [32:0]        sigq;
	logic [35:0]        logq;
	logic [VW-1:0]      fmag;
	val_t               fres;
	logic signed [17:0] onem;
	logic signed [33:0] dval;
	logic [VW-1:0]      gmag;
	logic [48:0]        lp;

	val_t               fres_s1;
	logic signed [33:0] d_s1;
	logic [48:0]        lp_s1;
	logic [VW-1:0]      gm_s1;
	carry_t             c_s1;
	logic               v_s1;

	logic [31:0]        dmag;
	val_t               fres_s2;
	logic [47:0]        bp_s2;
	logic               dneg_s2;
	logic [48:0]        lp_s2;
	logic [VW-1:0]      gm_s2;
	carry_t             c_s2;
	logic               v_s2;

	logic [25:0]        bmag;
	logic               bneg;
	logic signed [27:0] bsum;
	val_t               bres;
	logic               bsat;

	val_t               res_s3;
	logic               sat_s3;
	logic               bad_s3;
	logic               v_s3;

	// forward value and backward derivative
	always_comb begin
		q2   = {cin.q, 1'b0};
		sigq = cin.x[VW-1] ? {1'b0, q2} : (ONE_Q32 - {1'b0, q2});
		logq = 36'(cin.lk) * 36'(LN2_Q32) + {2'b0, cin.lsum, 1'b0};
		case (cin.fn)
			FN_SIGM: fmag = rnd(36'(sigq));
			FN_TANH: fmag = rnd(36'(q2));
			default: fmag = rnd(logq);
		endcase
		case (cin.fn)
			FN_IDENT: fres = cin.x;
			FN_RELU:  fres = (!cin.x[VW-1] && cin.x != '0) ? cin.x : '0;
			FN_SIGM:  fres = val_t'(fmag);
			default:  fres = cin.x[VW-1] ? val_t'(-fmag) : val_t'(fmag);
		endcase
		onem = 18'sd2048 - 18'(cin.y);
		if (cin.fn == FN_TANH) dval = (34'sd1 <<< (2 * FB)) - 34'(cin.y) * 34'(cin.y);
		else dval = 34'(cin.y) * 34'(onem);
		gmag = cin.g[VW-1] ? VW'(-cin.g) : VW'(cin.g);
		lp   = cin.e * gmag;
	end

	// backward product and final result
	always_comb begin
		dmag = d_s1[33] ? 32'(-d_s1) : 32'(d_s1);
		case (c_s2.fn)
			FN_SIGM, FN_TANH: begin
				bmag = 26'((bp_s2 + (48'd1 << (2 * FB - 1))) >> (2 * FB));
				bneg = dneg_s2 ^ c_s2.g[VW-1];
			end
			FN_LOGM: begin
				bmag = 26'((lp_s2 + (49'd1 << 31)) >> 32);
				bneg = c_s2.g[VW-1];
			end
			FN_RELU: begin
				bmag = (!c_s2.y[VW-1] && c_s2.y != '0) ? 26'(gm_s2) : '0;
				bneg = c_s2.g[VW-1];
			end
			default: begin
				bmag = 26'(gm_s2);
				bneg = c_s2.g[VW-1];
			end
		endcase
		bsum = 28'(c_s2.acc) + (bneg ? -$signed({2'b0, bmag}) : $signed({2'b0, bmag}));
		if (bsum > 28'sd32767) begin
			bres = 16'sh7fff;
			bsat = 1'b1;
		end else if (bsum < -28'sd32768) begin
			bres = 16'sh8000;
			bsat = 1'b1;
		end else begin
			bres = VW'(bsum);
			bsat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fres_s1 <= fres;
			d_s1    <= dval;
			lp_s1   <= lp;
			gm_s1   <= gmag;
			c_s1    <= cin;
			fres_s2 <= fres_s1;
			bp_s2   <= dmag * gm_s1;
			dneg_s2 <= d_s1[33];
			lp_s2   <= lp_s1;
			gm_s2   <= gm_s1;
			c_s2    <= c_s1;
			if (c_s2.bad) begin
				res_s3 <= '0;
				sat_s3 <= 1'b0;
			end else if (c_s2.act == ACT_FWD) begin
				res_s3 <= fres_s2;
				sat_s3 <= 1'b0;
			end else begin
				res_s3 <= bres;
				sat_s3 <= bsat;
			end
			bad_s3 <= c_s2.bad;
		end
	end

	assign vout   = v_s3;
	assign result = res_s3;
	assign sat    = sat_s3;
	assign bad    = bad_s3;
endmodule
`default_nettype wire
